>>> hdl/assert_macros.svh
// Shared assertion macros for the signal light voter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SLWV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLWV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/slwv_pkg.sv
`default_nettype none

package slwv_pkg;

    localparam int CNT_W = 9;

    localparam logic [1:0] LAMP_OFF     = 2'd0;
    localparam logic [1:0] LAMP_ON      = 2'd1;
    localparam logic [1:0] LAMP_BLINK   = 2'd2;
    localparam logic [1:0] LAMP_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] CFG_TOL_MISSES = 2'd1;
    localparam logic [1:0] CFG_MAX_JUMP   = 2'd2;

    typedef struct packed {
        logic               kind;
        logic               red_on;
        logic               yellow_on;
        logic               green_on;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } in_t;

    typedef struct packed {
        logic [1:0]         red_state;
        logic [1:0]         yellow_state;
        logic [1:0]         green_state;
        logic signed [15:0] visibility;
        logic               ready_res;
    } out_t;

    typedef struct packed {
        logic               green;
        logic               yellow;
        logic               red;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic pair;
    } jump_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_GRADE,
        S_FIN
    } state_t;

    function automatic logic [1:0] grade_lamp(input logic [CNT_W-1:0] cnt,
                                              input logic [CNT_W-1:0] n,
                                              input logic [5:0] tol);
        logic signed [CNT_W+2:0] c;
        logic signed [CNT_W+2:0] nn;
        logic signed [CNT_W+2:0] t;
        logic signed [CNT_W+2:0] h;
        logic [1:0]              g;
        c  = $signed({3'b000, cnt});
        nn = $signed({3'b000, n});
        t  = $signed({{(CNT_W-3){1'b0}}, tol});
        h  = $signed({4'b0000, n[CNT_W-1:1]});
        if (c >= nn - t)
            g = LAMP_ON;
        else if (c >= h - t && c <= h + t)
            g = LAMP_BLINK;
        else if (c <= t)
            g = LAMP_OFF;
        else
            g = LAMP_UNKNOWN;
        return g;
    endfunction

endpackage

`default_nettype wire

>>> hdl/slwv_cell.sv
`default_nettype none

module slwv_cell
    import slwv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire entry_t d,
    output entry_t      q
);

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= d;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

>>> hdl/slwv_ring.sv
`default_nettype none

module slwv_ring
    import slwv_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic   clk,
    input  wire logic   shift,
    input  wire logic   load_new,
    input  wire entry_t new_entry,
    output entry_t      tap
);

    entry_t cell_q [DEPTH];
    entry_t cell_d [DEPTH];

    // cell 0 takes the new frame or, while walking, the oldest cell (rotation)
    assign cell_d[0] = load_new ? new_entry : cell_q[DEPTH-1];

    genvar i;
    generate
        for (i = 1; i < DEPTH; i++)
        begin : g_link
            assign cell_d[i] = cell_q[i-1];
        end
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            slwv_cell u_cell (
                .clk (clk),
                .en  (shift),
                .d   (cell_d[i]),
                .q   (cell_q[i])
            );
        end
    endgenerate

    assign tap = cell_q[DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/slwv_jump.sv
`default_nettype none

module slwv_jump
    import slwv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jump_ctl_t          ctl,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic [32:0]        max_jump,
    output logic                    ok
);

    logic signed [15:0] prev_x_reg;
    logic signed [15:0] prev_y_reg;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic [31:0]        sqx_reg;
    logic [31:0]        sqy_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               ok_reg;

    logic [16:0]        dx_next;
    logic [16:0]        dy_next;
    logic signed [33:0] sqx_full;
    logic signed [33:0] sqy_full;
    logic [32:0]        d2;

    assign dx_next  = {pos_x[15], pos_x} - {prev_x_reg[15], prev_x_reg};
    assign dy_next  = {pos_y[15], pos_y} - {prev_y_reg[15], prev_y_reg};
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // stage 1: difference, stage 2: squares, stage 3: compare
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            prev_x_reg <= pos_x;
            prev_y_reg <= pos_y;
            dx_reg     <= $signed(dx_next);
            dy_reg     <= $signed(dy_next);
        end
        sqx_reg <= sqx_full[31:0];
        sqy_reg <= sqy_full[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ok_reg <= 1'b1;
        end
        else if (ctl.clear)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ok_reg <= 1'b1;
        end
        else
        begin
            v1_reg <= ctl.step && ctl.pair;
            v2_reg <= v1_reg;
            if (v2_reg && !(d2 < max_jump))
                ok_reg <= 1'b0;
        end
    end

    assign ok = ok_reg;

endmodule

`default_nettype wire

>>> hdl/signal_light_window_voter_core.sv
// Signal light window voter.
// in: one beat per camera frame (valid/ready), in_data.kind selects an
//   observation or a loss event. out: exactly one result beat per input beat,
//   in order. cfg: register writes (valid/ready, always ready), index 0 window
//   length, 1 tolerated misses, 2 squared jump limit; write only when idle.
// Sequence: a loss event or an observation that leaves the window short of full
//   goes from idle straight to the finish state, which loads the output
//   register and returns to idle, where the next beat can be taken. An
//   observation that fills the window rotates the frame ring once through the
//   distance pipeline, one cell per cycle, through the walk, drain, grade and
//   finish states before its result is registered.
// Throughput: one item at a time; the next beat is taken as soon as the
//   previous result sits in the output register.
// Stall: a result waits in the output register while out_ready is low; the
//   next item is still accepted and holds its result until the register frees.
// Reset: ring empty, visibility 0, reported lamps off, registers at defaults
//   (window 16, misses 2, jump limit 16384).
`default_nettype none
`include "assert_macros.svh"

module signal_light_window_voter_core
    import slwv_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [32:0] cfg_data
);

    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int KW = $clog2(RING_DEPTH);
    localparam int WW = (CW > 6) ? CW : 6;

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            drain_reg, drain_next;
    logic [CW-1:0]   cnt_r_reg, cnt_r_next;
    logic [CW-1:0]   cnt_y_reg, cnt_y_next;
    logic [CW-1:0]   cnt_g_reg, cnt_g_next;
    logic signed [15:0] vis_reg, vis_next;
    logic [5:0]      rep_reg, rep_next;
    logic            rdy_reg, rdy_next;
    logic            out_valid_reg, out_valid_next;
    out_t            out_data_reg, out_data_next;

    logic [5:0]      win_len_reg;
    logic [5:0]      tol_reg;
    logic [32:0]     max_jump_reg;

    logic [WW-1:0]   win_w;
    logic [WW-1:0]   cap_w;
    logic [CW-1:0]   cap;
    logic [CW:0]     fill_p1;
    logic [CW-1:0]   fill_inc;
    logic            accept;

    logic            ring_shift;
    logic            ring_load;
    entry_t          new_entry;
    entry_t          tap;
    jump_ctl_t       jctl;
    logic            jump_ok;

    logic            do_reset;
    logic            do_write;
    logic [5:0]      wr_states;
    logic            wr_flag;
    logic            wr_restart;
    logic signed [15:0] vis_wr;
    logic [1:0]      gr_r, gr_y, gr_g;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg  <= 6'd16;
            tol_reg      <= 6'd2;
            max_jump_reg <= 33'd16384;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEN: win_len_reg  <= cfg_data[5:0];
                CFG_TOL_MISSES: tol_reg      <= cfg_data[5:0];
                CFG_MAX_JUMP:   max_jump_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective window, clamped to 1..RING_DEPTH
    always_comb
    begin
        win_w = WW'(win_len_reg);
        if (win_w == '0)
            cap_w = WW'(1);
        else if (win_w > WW'(RING_DEPTH))
            cap_w = WW'(RING_DEPTH);
        else
            cap_w = win_w;
    end
    assign cap = cap_w[CW-1:0];

    assign fill_p1  = {1'b0, fill_reg} + (CW+1)'(1);
    assign fill_inc = (fill_p1 < {1'b0, cap}) ? fill_p1[CW-1:0] : cap;

    assign new_entry.green  = in_data.green_on;
    assign new_entry.yellow = in_data.yellow_on;
    assign new_entry.red    = in_data.red_on;
    assign new_entry.pos_y  = in_data.pos_y;
    assign new_entry.pos_x  = in_data.pos_x;

    assign gr_r = grade_lamp(CNT_W'(cnt_r_reg), CNT_W'(fill_reg), tol_reg);
    assign gr_y = grade_lamp(CNT_W'(cnt_y_reg), CNT_W'(fill_reg), tol_reg);
    assign gr_g = grade_lamp(CNT_W'(cnt_g_reg), CNT_W'(fill_reg), tol_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        drain_next     = drain_reg;
        cnt_r_next     = cnt_r_reg;
        cnt_y_next     = cnt_y_reg;
        cnt_g_next     = cnt_g_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ring_shift     = 1'b0;
        ring_load      = 1'b0;
        jctl           = '0;
        do_reset       = 1'b0;
        do_write       = 1'b0;
        wr_states      = '0;
        wr_flag        = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.kind)
                    begin
                        fill_next  = '0;
                        do_reset   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ring_shift = 1'b1;
                        ring_load  = 1'b1;
                        fill_next  = fill_inc;
                        if (fill_inc < cap)
                        begin
                            do_write   = 1'b1;
                            wr_states  = {1'b0, in_data.green_on, 1'b0, in_data.yellow_on,
                                          1'b0, in_data.red_on};
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = KW'(RING_DEPTH - 1);
                            cnt_r_next = '0;
                            cnt_y_next = '0;
                            cnt_g_next = '0;
                            jctl.clear = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WALK:
            begin
                // tap shows the k-th newest frame, oldest first
                ring_shift = 1'b1;
                jctl.step  = 1'b1;
                jctl.pair  = ((CW+1)'(k_reg) + (CW+1)'(1)) < {1'b0, fill_reg};
                if (CW'(k_reg) < fill_reg)
                begin
                    cnt_r_next = cnt_r_reg + CW'(tap.red);
                    cnt_y_next = cnt_y_reg + CW'(tap.yellow);
                    cnt_g_next = cnt_g_reg + CW'(tap.green);
                end
                if (k_reg == '0)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
                else
                    k_next = k_reg - KW'(1);
            end
            S_DRAIN:
            begin
                if (drain_reg)
                    state_next = S_GRADE;
                else
                    drain_next = 1'b1;
            end
            S_GRADE:
            begin
                if (!jump_ok || gr_r == LAMP_UNKNOWN || gr_y == LAMP_UNKNOWN
                    || gr_g == LAMP_UNKNOWN
                    || (gr_r == LAMP_OFF && gr_y == LAMP_OFF && gr_g == LAMP_OFF))
                    do_reset = 1'b1;
                else
                begin
                    do_write  = 1'b1;
                    wr_states = {gr_g, gr_y, gr_r};
                    wr_flag   = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.red_state    = rep_reg[1:0];
                    out_data_next.yellow_state = rep_reg[3:2];
                    out_data_next.green_state  = rep_reg[5:4];
                    out_data_next.visibility   = vis_reg;
                    out_data_next.ready_res    = rdy_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // report update
    assign wr_restart = vis_reg[15] || (wr_states != rep_reg);

    always_comb
    begin
        if (wr_restart)
            vis_wr = 16'sd1;
        else if (vis_reg != 16'sh7FFF)
            vis_wr = vis_reg + 16'sd1;
        else
            vis_wr = vis_reg;
    end

    always_comb
    begin
        vis_next = vis_reg;
        rep_next = rep_reg;
        rdy_next = rdy_reg;
        priority if (do_reset)
        begin
            if (!vis_reg[15])
                vis_next = -16'sd1;
            else if (vis_reg != 16'sh8000)
                vis_next = vis_reg - 16'sd1;
            rdy_next = 1'b0;
        end
        else if (do_write)
        begin
            vis_next = vis_wr;
            rep_next = wr_states;
            rdy_next = wr_flag && !wr_restart && ($unsigned(vis_wr) >= 16'(cap));
        end
        else
        begin
            rdy_next = rdy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            vis_reg       <= '0;
            rep_reg       <= '0;
            rdy_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            vis_reg       <= vis_next;
            rep_reg       <= rep_next;
            rdy_reg       <= rdy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_r_reg    <= cnt_r_next;
        cnt_y_reg    <= cnt_y_next;
        cnt_g_reg    <= cnt_g_next;
        out_data_reg <= out_data_next;
    end

    slwv_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk       (clk),
        .shift     (ring_shift),
        .load_new  (ring_load),
        .new_entry (new_entry),
        .tap       (tap)
    );

    slwv_jump u_jump (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (jctl),
        .pos_x    (tap.pos_x),
        .pos_y    (tap.pos_y),
        .max_jump (max_jump_reg),
        .ok       (jump_ok)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SLWV_ASSERT(a_out_from_fin, $rose(out_valid_reg) |-> $past(state_reg == S_FIN),
        "result beat not issued from finish state")
    `SLWV_ASSERT_NEXT(a_loss_empties, accept && in_data.kind, fill_reg == '0,
        "loss event did not empty the ring")
    `SLWV_ASSERT(a_vis_nonzero, out_valid_reg |-> out_data_reg.visibility != 16'sd0,
        "result beat with zero visibility")
    `SLWV_ASSERT(a_ready_pos, (out_valid_reg && out_data_reg.ready_res)
        |-> !out_data_reg.visibility[15], "ready report with negative visibility")

endmodule

`default_nettype wire

>>> sim/tb_signal_light_window_voter_core.sv
`default_nettype none

module tb_signal_light_window_voter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import slwv_pkg::*;

    localparam int RING_DEPTH    = 32;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 250;
    localparam int FLOOR_RUN     = 40;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [32:0] reg_val;
        in_t         frame;
        logic        typed;
        out_t        want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WINDOW_LEN;
    logic [32:0] cfg_data = '0;

    // shadow of the block
    entry_t      frame_mem [RING_DEPTH];
    int          frames_held = 0;
    int          newest = 0;
    int          vis_run = 0;
    logic [5:0]  shown = '0;
    logic [5:0]  win_reg = 6'd16;
    logic [5:0]  miss_reg = 6'd2;
    logic [32:0] jump_reg = 33'd16384;

    out_t        pending_reports [$];
    plan_row_t   plan [$];
    out_t        due;

    int          mismatches = 0;
    int          frames_sent = 0;
    int          losses_sent = 0;
    int          reg_writes = 0;
    int          results_seen = 0;
    int          ready_seen = 0;
    int          vis_low = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    logic        gaps_on = 1'b1;
    logic        stalls_on = 1'b1;

    // random frame source
    int          win_pick [RANDOM_PHASES] = '{4, 1, 32, 0, 63, 3, 6, 2};
    int          tol_pick [RANDOM_PHASES] = '{1, 0, 32, 63, 2, 0, 1, 3};
    int          lamp_mode [3];
    int          step_max;
    int          jump_by;
    int          loss_pm;
    int          noise_pm;
    int          roll;
    int          dxv;
    int          dyv;
    int          tick = 0;
    logic [2:0]  lit;
    logic [32:0] jump_val;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    in_t         fr;

    signal_light_window_voter_core #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic in_t mk_frame(input logic kind, input logic r, input logic y,
                                     input logic g, input int x, input int yy);
        in_t f;
        f.kind      = kind;
        f.red_on    = r;
        f.yellow_on = y;
        f.green_on  = g;
        f.pos_x     = x[15:0];
        f.pos_y     = yy[15:0];
        return f;
    endfunction

    function automatic out_t mk_report(input logic [1:0] r, input logic [1:0] y,
                                       input logic [1:0] g, input int vis, input logic rdy);
        out_t o;
        o.red_state    = r;
        o.yellow_state = y;
        o.green_state  = g;
        o.visibility   = vis[15:0];
        o.ready_res    = rdy;
        return o;
    endfunction

    function automatic plan_row_t frame_row(input in_t f, input logic typed, input out_t want);
        plan_row_t p;
        p = '0;
        p.frame = f;
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [32:0] val);
        plan_row_t p;
        p = '0;
        p.is_cfg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    function automatic int span_len();
        int w;
        w = int'(win_reg);
        if (w < 1)
            w = 1;
        if (w > RING_DEPTH)
            w = RING_DEPTH;
        return w;
    endfunction

    function automatic logic [1:0] vote_lamp(input int cnt, input int n, input int t);
        if (cnt >= n - t)
            return LAMP_ON;
        if (cnt >= n / 2 - t && cnt <= n / 2 + t)
            return LAMP_BLINK;
        if (cnt <= t)
            return LAMP_OFF;
        return LAMP_UNKNOWN;
    endfunction

    function automatic void drop_report();
        if (vis_run < 0)
        begin
            if (vis_run > -32768)
                vis_run--;
        end
        else
            vis_run = -1;
    endfunction

    function automatic logic post_report(input logic [5:0] st, input logic ok);
        logic held;
        held = ok;
        if (vis_run < 0 || st != shown)
        begin
            vis_run = 1;
            held = 1'b0;
        end
        else if (vis_run < 32767)
            vis_run++;
        shown = st;
        return held && (vis_run >= span_len());
    endfunction

    function automatic out_t vote_frame(input in_t f);
        out_t       res;
        entry_t     e;
        entry_t     prev;
        int         cap;
        int         k;
        int         cr;
        int         cy;
        int         cg;
        longint     dx;
        longint     dy;
        logic       steady;
        logic       rdy;
        logic [1:0] gr;
        logic [1:0] gy2;
        logic [1:0] gg;
        cap = span_len();
        rdy = 1'b0;
        prev = '0;
        if (f.kind)
        begin
            frames_held = 0;
            newest = 0;
            drop_report();
        end
        else
        begin
            newest = (newest + 1) % RING_DEPTH;
            e.red    = f.red_on;
            e.yellow = f.yellow_on;
            e.green  = f.green_on;
            e.pos_x  = f.pos_x;
            e.pos_y  = f.pos_y;
            frame_mem[newest] = e;
            frames_held = (frames_held + 1 < cap) ? frames_held + 1 : cap;
            if (frames_held < cap)
                rdy = post_report({1'b0, f.green_on, 1'b0, f.yellow_on, 1'b0, f.red_on}, 1'b0);
            else
            begin
                cr = 0;
                cy = 0;
                cg = 0;
                steady = 1'b1;
                for (k = 0; k < frames_held; k++)
                begin
                    e = frame_mem[(newest + RING_DEPTH - k) % RING_DEPTH];
                    if (k > 0)
                    begin
                        dx = longint'($signed(e.pos_x)) - longint'($signed(prev.pos_x));
                        dy = longint'($signed(e.pos_y)) - longint'($signed(prev.pos_y));
                        if (dx * dx + dy * dy >= longint'({31'b0, jump_reg}))
                        begin
                            steady = 1'b0;
                            break;
                        end
                    end
                    cr += int'(e.red);
                    cy += int'(e.yellow);
                    cg += int'(e.green);
                    prev = e;
                end
                if (!steady)
                    drop_report();
                else
                begin
                    gr  = vote_lamp(cr, frames_held, int'(miss_reg));
                    gy2 = vote_lamp(cy, frames_held, int'(miss_reg));
                    gg  = vote_lamp(cg, frames_held, int'(miss_reg));
                    if (gr != LAMP_UNKNOWN && gy2 != LAMP_UNKNOWN && gg != LAMP_UNKNOWN
                        && !(gr == LAMP_OFF && gy2 == LAMP_OFF && gg == LAMP_OFF))
                        rdy = post_report({gg, gy2, gr}, 1'b1);
                    else
                        drop_report();
                end
            end
        end
        res.red_state    = shown[1:0];
        res.yellow_state = shown[3:2];
        res.green_state  = shown[5:4];
        res.visibility   = vis_run[15:0];
        res.ready_res    = rdy;
        return res;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_LEN: win_reg = val[5:0];
            CFG_TOL_MISSES: miss_reg = val[5:0];
            CFG_MAX_JUMP:   jump_reg = val;
            default:        ;
        endcase
        reg_writes++;
    endtask

    task automatic send_frame(input in_t f, input logic typed, input out_t want);
        out_t guess;
        int   gap;
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = vote_frame(f);
        pending_reports.push_back(typed ? want : guess);
        frames_sent++;
        if (f.kind)
            losses_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_reports.size() == 0)
                begin
                    $error("result beat with no report pending");
                    mismatches++;
                end
                else
                begin
                    due = pending_reports[0];
                    pending_reports.delete(0);
                    if (out_data.red_state !== due.red_state)
                    begin
                        $error("red_state: expected %0d, got %0d",
                               due.red_state, out_data.red_state);
                        mismatches++;
                    end
                    if (out_data.yellow_state !== due.yellow_state)
                    begin
                        $error("yellow_state: expected %0d, got %0d",
                               due.yellow_state, out_data.yellow_state);
                        mismatches++;
                    end
                    if (out_data.green_state !== due.green_state)
                    begin
                        $error("green_state: expected %0d, got %0d",
                               due.green_state, out_data.green_state);
                        mismatches++;
                    end
                    if (out_data.visibility !== due.visibility)
                    begin
                        $error("visibility: expected %0d, got %0d",
                               due.visibility, out_data.visibility);
                        mismatches++;
                    end
                    if (out_data.ready_res !== due.ready_res)
                    begin
                        $error("ready_res: expected %0d, got %0d",
                               due.ready_res, out_data.ready_res);
                        mismatches++;
                    end
                    if (out_data.ready_res === 1'b1)
                        ready_seen++;
                    if (int'($signed(out_data.visibility)) < vis_low)
                        vis_low = int'($signed(out_data.visibility));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = $urandom_range(0, 10);
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        // reset defaults: window 16, two misses, jump 16384
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 0, 0), 1,
                                 mk_report(LAMP_ON, LAMP_OFF, LAMP_OFF, 1, 0)));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 0, 0), 1,
                                 mk_report(LAMP_ON, LAMP_OFF, LAMP_OFF, 2, 0)));
        plan.push_back(frame_row(mk_frame(1, 1, 1, 1, -32768, 32767), 1,
                                 mk_report(LAMP_ON, LAMP_OFF, LAMP_OFF, -1, 0)));
        plan.push_back(frame_row(mk_frame(1, 0, 0, 0, 32767, -32768), 1,
                                 mk_report(LAMP_ON, LAMP_OFF, LAMP_OFF, -2, 0)));
        plan.push_back(frame_row(mk_frame(0, 1, 1, 1, 32767, -32768), 1,
                                 mk_report(LAMP_ON, LAMP_ON, LAMP_ON, 1, 0)));
        // zero window behaves as one
        plan.push_back(cfg_row(CFG_WINDOW_LEN, 33'd0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 1, 0, 0), 1,
                                 mk_report(LAMP_ON, LAMP_ON, LAMP_ON, 2, 1)));
        plan.push_back(cfg_row(CFG_TOL_MISSES, 33'd0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 1, 0, 0), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 0, 0, 0), 0, '0));
        plan.push_back(cfg_row(CFG_WINDOW_LEN, 33'd2));
        plan.push_back(cfg_row(CFG_MAX_JUMP, 33'd0));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 1, 1), 0, '0));
        plan.push_back(cfg_row(CFG_MAX_JUMP, 33'h1_FFFF_FFFF));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, -32768, -32768), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 32767, 32767), 0, '0));
        // jump right at the limit, then just below it
        plan.push_back(cfg_row(CFG_MAX_JUMP, 33'd16384));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 32639, 32767), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 32512, 32767), 0, '0));
        // grown window sees a 3-of-4 red count: unknown
        plan.push_back(cfg_row(CFG_WINDOW_LEN, 33'd4));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 32512, 32767), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 0, 32512, 32767), 0, '0));
        // shrink while full, then blinking red, then all dark
        plan.push_back(cfg_row(CFG_WINDOW_LEN, 33'd2));
        plan.push_back(frame_row(mk_frame(0, 1, 0, 0, 32512, 32767), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 0, 32512, 32767), 0, '0));
        plan.push_back(frame_row(mk_frame(0, 0, 0, 0, 32512, 32767), 0, '0));
        plan.push_back(cfg_row(CFG_WINDOW_LEN, 33'd63));
        plan.push_back(cfg_row(CFG_TOL_MISSES, 33'd32));
        plan.push_back(frame_row(mk_frame(0, 0, 1, 0, -1, -1), 0, '0));
        plan.push_back(frame_row(mk_frame(1, 0, 0, 0, 0, 0), 0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_frame(plan[i].frame, plan[i].typed, plan[i].want);
        end

        // back-to-back loss run keeps visibility falling
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (FLOOR_RUN)
        begin
            fr = mk_frame(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom, $urandom);
            send_frame(fr, 1'b0, '0);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            step_max = $urandom_range(4, 120);
            jump_val = 33'(2 * (step_max + 1) * (step_max + 1) + $urandom_range(0, 500));
            if (ph == 1)
                jump_val = 33'h1_FFFF_FFFF;
            else if (ph == 5)
                jump_val = '0;
            else if (ph == 7)
                jump_val = {1'($urandom_range(0, 1)), $urandom};
            write_reg(CFG_WINDOW_LEN, 33'(win_pick[ph]));
            write_reg(CFG_TOL_MISSES, 33'(tol_pick[ph]));
            write_reg(CFG_MAX_JUMP, jump_val);
            gaps_on = (ph % 3 != 2);
            stalls_on = (ph % 4 != 3);
            loss_pm = (span_len() >= 16) ? 4 : 15;
            noise_pm = (span_len() >= 16) ? 4 : 40;
            gx = 16'($urandom);
            gy = 16'($urandom);
            foreach (lamp_mode[j])
                lamp_mode[j] = $urandom_range(0, 2);
            repeat (PHASE_FRAMES)
            begin
                roll = $urandom_range(0, 999);
                if (roll < loss_pm)
                    fr = mk_frame(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), $urandom, $urandom);
                else if (roll < loss_pm + noise_pm)
                    fr = mk_frame(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                begin
                    jump_by = ($urandom_range(0, 99) == 0) ? 3 * step_max + 64 : step_max;
                    dxv = int'($urandom_range(0, 2 * jump_by)) - jump_by;
                    dyv = int'($urandom_range(0, 2 * jump_by)) - jump_by;
                    gx = gx + dxv[15:0];
                    gy = gy + dyv[15:0];
                    if ($urandom_range(0, 49) == 0)
                    begin
                        foreach (lamp_mode[j])
                            lamp_mode[j] = $urandom_range(0, 2);
                    end
                    tick++;
                    foreach (lamp_mode[j])
                        lit[j] = (lamp_mode[j] == 1 || (lamp_mode[j] == 2 && tick % 2 == 1))
                                 ^ ($urandom_range(0, 29) == 0);
                    fr = mk_frame(1'b0, lit[0], lit[1], lit[2], int'(gx), int'(gy));
                end
                send_frame(fr, 1'b0, '0);
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (RING_DEPTH + 8) @(posedge clk);
        $display("ran %0d frames, %0d of them loss events, across %0d register writes",
                 frames_sent, losses_sent, reg_writes);
        $display("checked %0d reports, %0d flagged ready, visibility went down to %0d",
                 results_seen, ready_seen, vis_low);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
